// ----- rtl/otcp_pkg.sv -----
// otcp_pkg: shared types, codes and text tables for the OpusTags comment parser
// used by otcp_core, otcp_out_buf and opus_tags_comment_parser
package otcp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int PLEN_W          = 16;
    localparam int MAXLEN_W        = 16;
    localparam int NUM_KEYS        = 5;
    localparam int MAGIC_LEN       = 8;
    localparam int MIN_PACKET      = 16;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = 16'd256;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_VLEN,
        PH_VENDOR,
        PH_FCOUNT,
        PH_CLEN,
        PH_COMMENT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VENDOR = 2'd0,
        KIND_TAG    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [PLEN_W-1:0] packet_length;
        logic              first_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [2:0]  tag_index;
        logic [7:0]  value_byte;
        logic        status;
        logic        end_of_packet;
    } result_t;

    // up to two results per byte, entry 0 goes out first
    typedef struct packed {
        logic [1:0]         cnt;
        result_t [1:0]      ent;
    } push_t;

    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h4F;
            3'd1:    c = 8'h70;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h54;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h67;
            default: c = 8'h73;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] key_len(input logic [2:0] key);
        logic [2:0] n;
        unique case (key)
            3'd0:    n = 3'd6;
            3'd1:    n = 3'd7;
            3'd2:    n = 3'd6;
            3'd3:    n = 3'd5;
            default: n = 3'd6;
        endcase
        return n;
    endfunction

    // lower-case key text including the trailing '='
    function automatic logic [7:0] key_char(input logic [2:0] key, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (key)
            3'd0: begin
                unique case (pos)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h69;
                    3'd2:    c = 8'h74;
                    3'd3:    c = 8'h6C;
                    3'd4:    c = 8'h65;
                    3'd5:    c = 8'h3D;
                    default: c = 8'h00;
                endcase
            end
            3'd1: begin
                unique case (pos)
                    3'd0:    c = 8'h61;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h74;
                    3'd3:    c = 8'h69;
                    3'd4:    c = 8'h73;
                    3'd5:    c = 8'h74;
                    3'd6:    c = 8'h3D;
                    default: c = 8'h00;
                endcase
            end
            3'd2: begin
                unique case (pos)
                    3'd0:    c = 8'h61;
                    3'd1:    c = 8'h6C;
                    3'd2:    c = 8'h62;
                    3'd3:    c = 8'h75;
                    3'd4:    c = 8'h6D;
                    3'd5:    c = 8'h3D;
                    default: c = 8'h00;
                endcase
            end
            3'd3: begin
                unique case (pos)
                    3'd0:    c = 8'h64;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h74;
                    3'd3:    c = 8'h65;
                    3'd4:    c = 8'h3D;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h61;
                    3'd3:    c = 8'h63;
                    3'd4:    c = 8'h6B;
                    3'd5:    c = 8'h3D;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/otcp_out_buf.sv -----
// otcp_out_buf: two-word result buffer feeding the master stream side
// depends on otcp_pkg
module otcp_out_buf
    import otcp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  push_t      push,
    output logic [1:0] free,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    logic [1:0]    count_reg, count_next;
    result_t [1:0] slot_reg, slot_next;
    logic          pop;
    logic [1:0]    cnt_a;

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign free      = 2'd2 - count_reg;
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot_reg[0];

    always_comb begin
        slot_next = slot_reg;
        cnt_a     = count_reg;
        if (pop) begin
            slot_next[0] = slot_reg[1];
            cnt_a        = count_reg - 2'd1;
        end
        case (cnt_a)
            2'd0: begin
                if (push.cnt != 2'd0) slot_next[0] = push.ent[0];
                if (push.cnt == 2'd2) slot_next[1] = push.ent[1];
            end
            2'd1: begin
                if (push.cnt != 2'd0) slot_next[1] = push.ent[0];
            end
            default: ;
        endcase
        count_next = cnt_a + push.cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot_reg <= slot_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("result buffer overfilled");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt <= free)
        else $error("results pushed without room");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("waiting word changed or dropped");

endmodule

// ----- rtl/otcp_core.sv -----
// otcp_core: parser state and per-byte decode, magic, lengths, key match and value copy
// depends on otcp_pkg
module otcp_core
    import otcp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  item_t               item,
    input  logic [MAXLEN_W-1:0] max_len,
    output push_t               push
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = 33;

    phase_t              phase_reg, phase_next;
    logic [LB-1:0]       bl_reg, bl_next;
    logic [LB-1:0]       fc_reg, fc_next;
    logic [31:0]         ls_reg, ls_next;
    logic [LB-1:0]       fr_reg, fr_next;
    logic [NUM_KEYS-1:0] flags_reg, flags_next;
    logic [MAXLEN_W-1:0] cc_reg, cc_next;
    logic                cs_reg, cs_next;
    logic                err_reg, err_next;

    phase_t              ph;
    logic [LB-1:0]       bl, fc, fr;
    logic [31:0]         ls, newls;
    logic [NUM_KEYS-1:0] flags;
    logic [MAXLEN_W-1:0] cc;
    logic                cs, err;
    logic [LB:0]         fc_inc;
    logic [7:0]          b, low;
    logic                copy_req, copy_fire, found, bad;
    kind_t               copy_kind;
    logic [2:0]          copy_tag;
    result_t             copy_res, stat_res;

    always_comb begin
        b     = item.data_byte;
        low   = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        ph    = phase_reg;
        bl    = bl_reg;
        fc    = fc_reg;
        ls    = ls_reg;
        fr    = fr_reg;
        flags = flags_reg;
        cc    = cc_reg;
        cs    = cs_reg;
        err   = err_reg;
        if (item.first_byte) begin
            ph    = PH_MAGIC;
            bl    = LB'(item.packet_length);
            fc    = '0;
            ls    = '0;
            fr    = '0;
            flags = '1;
            cc    = '0;
            cs    = 1'b0;
            err   = (LB'(item.packet_length) < LB'(MIN_PACKET));
        end
        fc_inc    = {1'b0, fc} + (LB+1)'(1);
        newls     = ls | (32'(b) << {fc[1:0], 3'b000});
        copy_req  = 1'b0;
        copy_kind = KIND_VENDOR;
        copy_tag  = 3'd0;
        found     = 1'b0;

        if (!err && ph != PH_DONE) begin
            if (bl == '0) begin
                err = 1'b1;
            end else begin
                bl = bl - LB'(1);
                unique case (ph)
                    PH_MAGIC: begin
                        if (b != magic_char(fc[2:0])) begin
                            err = 1'b1;
                        end else begin
                            fc = fc_inc[LB-1:0];
                            if (CW'(fc_inc) >= CW'(MAGIC_LEN)) begin
                                ph = PH_VLEN;
                                fc = '0;
                                ls = '0;
                            end
                        end
                    end
                    PH_VLEN, PH_FCOUNT, PH_CLEN: begin
                        ls = newls;
                        fc = fc_inc[LB-1:0];
                        if (CW'(fc_inc) >= CW'(4)) begin
                            fc = '0;
                            if (ph == PH_VLEN) begin
                                if (bl < LB'(4) || newls > 32'(bl) - 32'd4) begin
                                    err = 1'b1;
                                end else if (newls == '0) begin
                                    ph = PH_FCOUNT;
                                end else begin
                                    ph = PH_VENDOR;
                                    cc = '0;
                                    cs = 1'b0;
                                end
                            end else if (ph == PH_FCOUNT) begin
                                if (newls > 32'(bl >> 2)) begin
                                    err = 1'b1;
                                end else begin
                                    fr = LB'(newls);
                                    if (fr == '0) begin
                                        ph = PH_DONE;
                                    end else if (bl < LB'(4)) begin
                                        err = 1'b1;
                                    end else begin
                                        ph = PH_CLEN;
                                        fc = '0;
                                        ls = '0;
                                    end
                                end
                            end else begin
                                if (newls > 32'(bl)) begin
                                    err = 1'b1;
                                end else begin
                                    for (int j = 0; j < NUM_KEYS; j++) begin
                                        flags[j] = (32'(key_len(3'(j))) <= newls);
                                    end
                                    cc = '0;
                                    cs = 1'b0;
                                    fc = '0;
                                    fr = fr - LB'(1);
                                    ph = PH_COMMENT;
                                    if (newls == '0) begin
                                        if (fr == '0) begin
                                            ph = PH_DONE;
                                        end else if (bl < LB'(4)) begin
                                            err = 1'b1;
                                        end else begin
                                            ph = PH_CLEN;
                                            ls = '0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    PH_VENDOR: begin
                        copy_req = 1'b1;
                        fc       = fc_inc[LB-1:0];
                        if (CW'(fc_inc) >= CW'(ls)) begin
                            ph = PH_FCOUNT;
                            fc = '0;
                            ls = '0;
                        end
                    end
                    PH_COMMENT: begin
                        for (int j = 0; j < NUM_KEYS; j++) begin
                            if (flags_reg[j] && !found && flags[j]) begin
                                if (fc < LB'(key_len(3'(j)))) begin
                                    if (low != key_char(3'(j), fc[2:0])) flags[j] = 1'b0;
                                end else begin
                                    found     = 1'b1;
                                    copy_req  = 1'b1;
                                    copy_kind = KIND_TAG;
                                    copy_tag  = 3'(j);
                                end
                            end
                        end
                        fc = fc_inc[LB-1:0];
                        if (CW'(fc_inc) >= CW'(ls)) begin
                            if (fr == '0) begin
                                ph = PH_DONE;
                            end else if (bl < LB'(4)) begin
                                err = 1'b1;
                            end else begin
                                ph = PH_CLEN;
                                fc = '0;
                                ls = '0;
                            end
                        end
                    end
                    default: ph = PH_DONE;
                endcase
            end
        end

        copy_fire = 1'b0;
        if (copy_req && !cs && cc < max_len) begin
            if (b == 8'h00) begin
                cs = 1'b1;
            end else begin
                cc        = cc + MAXLEN_W'(1);
                copy_fire = 1'b1;
            end
        end

        bad = err || (ph != PH_DONE);
        if (item.last_byte) begin
            ph    = PH_MAGIC;
            bl    = '0;
            fc    = '0;
            ls    = '0;
            fr    = '0;
            flags = '1;
            cc    = '0;
            cs    = 1'b0;
            err   = 1'b0;
        end

        copy_res.item_kind     = copy_kind;
        copy_res.tag_index     = copy_tag;
        copy_res.value_byte    = b;
        copy_res.status        = 1'b0;
        copy_res.end_of_packet = 1'b0;
        stat_res.item_kind     = KIND_STATUS;
        stat_res.tag_index     = 3'd0;
        stat_res.value_byte    = 8'h00;
        stat_res.status        = bad;
        stat_res.end_of_packet = 1'b1;

        if (copy_fire) begin
            push.ent[0] = copy_res;
            push.ent[1] = stat_res;
            push.cnt    = 2'd1 + {1'b0, item.last_byte};
        end else begin
            push.ent[0] = stat_res;
            push.ent[1] = stat_res;
            push.cnt    = {1'b0, item.last_byte};
        end

        phase_next = ph;
        bl_next    = bl;
        fc_next    = fc;
        ls_next    = ls;
        fr_next    = fr;
        flags_next = flags;
        cc_next    = cc;
        cs_next    = cs;
        err_next   = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            bl_reg    <= '0;
            fc_reg    <= '0;
            ls_reg    <= '0;
            fr_reg    <= '0;
            flags_reg <= '1;
            cc_reg    <= '0;
            cs_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            bl_reg    <= bl_next;
            fc_reg    <= fc_next;
            ls_reg    <= ls_next;
            fr_reg    <= fr_next;
            flags_reg <= flags_next;
            cc_reg    <= cc_next;
            cs_reg    <= cs_next;
            err_reg   <= err_next;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> phase_reg == PH_MAGIC && bl_reg == '0 && !err_reg)
        else $error("packet end did not clear the parser");

    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && err_reg && !item.first_byte |-> push.cnt == {1'b0, item.last_byte})
        else $error("value byte emitted after an error");

    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_DONE && !item.first_byte
            |-> push.cnt == {1'b0, item.last_byte})
        else $error("value byte emitted after parsing finished");

endmodule

// ----- rtl/opus_tags_comment_parser.sv -----
// opus_tags_comment_parser: top level, input word register, config register and wiring
// depends on otcp_pkg, otcp_core, otcp_out_buf
//
// usage: one packet byte per slave word; s_tuser marks the first byte (packet length
// sampled there from s_tdata), s_tlast the final byte. the master side carries vendor
// bytes, matched tag value bytes and one status word closing each packet (m_tlast).
// cfg_wr_en/cfg_wr_data write the per-string copy limit at any edge while idle.
// a taken byte waits in the input word register, is decoded from there once the buffer
// has room for its words, then its words enter the result buffer, which drives m_tvalid.
// throughput: one byte per cycle while m_tready is high and each byte makes at most one
// word; a last byte copying a value byte makes two words and needs both free slots.
// the input register and the two-word result buffer decouple the sides: when m_tready
// is low the buffer fills and then s_tready drops, with nothing lost or repeated.
// reset: copy limit 256, parser in the magic phase with no packet open, buffer empty.
module opus_tags_comment_parser
    import otcp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,  // data_byte, packet_length
    input  logic                s_tuser,  // first_byte
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,  // value_byte, status, zero pad
    output logic [4:0]          m_tuser,  // item_kind, tag_index
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [MAXLEN_W-1:0] cfg_wr_data
);

    logic [MAXLEN_W-1:0] max_len_reg;
    logic                in_valid_reg, in_valid_next;
    item_t               in_item_reg;
    push_t               push_raw, push;
    logic [1:0]          free;
    logic                fire, accept;
    result_t             out_res;

    assign fire     = in_valid_reg && (push_raw.cnt <= free);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        push     = push_raw;
        push.cnt = fire ? push_raw.cnt : 2'd0;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= MAX_LEN_RST;
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) max_len_reg <= cfg_wr_data;
        end
        if (accept) begin
            in_item_reg.data_byte     <= s_tdata[7:0];
            in_item_reg.packet_length <= s_tdata[23:8];
            in_item_reg.first_byte    <= s_tuser;
            in_item_reg.last_byte     <= s_tlast;
        end
    end

    otcp_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .max_len (max_len_reg),
        .push    (push_raw)
    );

    otcp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {7'd0, out_res.status, out_res.value_byte};
    assign m_tuser = {out_res.tag_index, out_res.item_kind};
    assign m_tlast = out_res.end_of_packet;

endmodule

// ----- sim/testbench.sv -----
// testbench for opus_tags_comment_parser: streams OpusTags packets byte by byte and
// checks vendor, tag value and status words against a cycle-free predictor
// depends on otcp_pkg and the rtl of opus_tags_comment_parser
module testbench;
    import otcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class tag_stream_board;
        result_t     expected_words[$];
        int unsigned errors;
        int unsigned copy_limit;
        string       magic_text;
        string       tag_keys[5];

        phase_t      phase;
        int unsigned bytes_left;
        int unsigned pos;
        int unsigned length_acc;
        int unsigned fields_left;
        bit [4:0]    key_live;
        int unsigned copied;
        bit          copy_halted;
        bit          bad;

        function new();
            magic_text  = "OpusTags";
            tag_keys[0] = "title=";
            tag_keys[1] = "artist=";
            tag_keys[2] = "album=";
            tag_keys[3] = "date=";
            tag_keys[4] = "track=";
            copy_limit  = 256;
            errors      = 0;
            clear();
        endfunction

        function void clear();
            phase       = PH_MAGIC;
            bytes_left  = 0;
            pos         = 0;
            length_acc  = 0;
            fields_left = 0;
            key_live    = '1;
            copied      = 0;
            copy_halted = 1'b0;
            bad         = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void emit(kind_t k, bit [2:0] tag, bit [7:0] v, bit st, bit eop);
            result_t r;
            r.item_kind     = k;
            r.tag_index     = tag;
            r.value_byte    = v;
            r.status        = st;
            r.end_of_packet = eop;
            expected_words.push_back(r);
        endfunction

        function void copy_out(bit [7:0] b, kind_t k, bit [2:0] tag);
            if (copy_halted || copied >= copy_limit)
                return;
            if (b == 8'h00) begin
                copy_halted = 1'b1;
                return;
            end
            copied++;
            emit(k, tag, b, 1'b0, 1'b0);
        endfunction

        function void advance_comment();
            if (fields_left == 0) begin
                phase = PH_DONE;
            end else if (bytes_left < 4) begin
                bad = 1'b1;
            end else begin
                phase      = PH_CLEN;
                pos        = 0;
                length_acc = 0;
            end
        endfunction

        function void open_comment();
            int j;
            key_live = '0;
            for (j = 0; j < NUM_KEYS; j++)
                if (tag_keys[j].len() <= length_acc)
                    key_live[j] = 1'b1;
            copied      = 0;
            copy_halted = 1'b0;
            pos         = 0;
            fields_left--;
            phase = PH_COMMENT;
            if (length_acc == 0)
                advance_comment();
        endfunction

        function void comment_char(bit [7:0] b);
            bit [7:0] low;
            int       j;
            low = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
            for (j = 0; j < NUM_KEYS; j++) begin
                if (!key_live[j])
                    continue;
                if (pos < tag_keys[j].len()) begin
                    if (low != tag_keys[j][pos])
                        key_live[j] = 1'b0;
                end else begin
                    copy_out(b, KIND_TAG, 3'(j));
                    break;
                end
            end
            pos++;
            if (pos >= length_acc)
                advance_comment();
        endfunction

        function void parse(bit [7:0] b);
            if (phase == PH_DONE)
                return;
            if (bytes_left == 0) begin
                bad = 1'b1;
                return;
            end
            bytes_left--;
            case (phase)
                PH_MAGIC: begin
                    if (b != magic_text[pos % 8]) begin
                        bad = 1'b1;
                        return;
                    end
                    pos++;
                    if (pos >= MAGIC_LEN) begin
                        phase      = PH_VLEN;
                        pos        = 0;
                        length_acc = 0;
                    end
                end
                PH_VLEN, PH_FCOUNT, PH_CLEN: begin
                    length_acc |= {24'd0, b} << (8 * (pos % 4));
                    pos++;
                    if (pos >= 4) begin
                        pos = 0;
                        if (phase == PH_VLEN) begin
                            if (bytes_left < 4 || length_acc > bytes_left - 4) begin
                                bad = 1'b1;
                            end else if (length_acc == 0) begin
                                phase = PH_FCOUNT;
                            end else begin
                                phase       = PH_VENDOR;
                                copied      = 0;
                                copy_halted = 1'b0;
                            end
                        end else if (phase == PH_FCOUNT) begin
                            if (length_acc > (bytes_left >> 2)) begin
                                bad = 1'b1;
                            end else begin
                                fields_left = length_acc;
                                advance_comment();
                            end
                        end else begin
                            if (length_acc > bytes_left)
                                bad = 1'b1;
                            else
                                open_comment();
                        end
                    end
                end
                PH_VENDOR: begin
                    copy_out(b, KIND_VENDOR, 3'd0);
                    pos++;
                    if (pos >= length_acc) begin
                        phase      = PH_FCOUNT;
                        pos        = 0;
                        length_acc = 0;
                    end
                end
                PH_COMMENT: begin
                    comment_char(b);
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
        endfunction

        function void note_byte(bit [7:0] b, bit [15:0] plen, bit f, bit l);
            if (f) begin
                clear();
                bytes_left = 32'(plen);
                if (bytes_left < MIN_PACKET)
                    bad = 1'b1;
            end
            if (!bad)
                parse(b);
            if (l) begin
                emit(KIND_STATUS, 3'd0, 8'h00, bad || phase != PH_DONE, 1'b1);
                clear();
            end
        endfunction

        function void check_word(bit [4:0] user, bit [15:0] data, bit eop);
            result_t want;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: expected no word, got kind %0d tag %0d byte %h",
                         $time, user[1:0], user[4:2], data[7:0],
                         " status %0d eop %0d", data[8], eop);
                return;
            end
            want = expected_words.pop_front();
            if (user[1:0] != want.item_kind || user[4:2] != want.tag_index ||
                data[7:0] != want.value_byte || data[8] != want.status ||
                data[15:9] != 7'd0 || eop != want.end_of_packet) begin
                errors++;
                $display("%0t: expected kind %0d tag %0d byte %h status %0d eop %0d pad 0,",
                         $time, want.item_kind, want.tag_index, want.value_byte,
                         want.status, want.end_of_packet,
                         " got kind %0d tag %0d byte %h status %0d eop %0d pad %h",
                         user[1:0], user[4:2], data[7:0], data[8], eop, data[15:9]);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    tag_stream_board sb = new();

    bit          idle_on = 1'b1;
    bit          hold_off = 1'b0;
    int unsigned words_sent = 0;
    bit [7:0]    pkt[$];
    int unsigned vendor_len;

    opus_tags_comment_parser DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata[7:0], s_tdata[23:8], s_tuser, s_tlast);
        end
    end

    // receiver side, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
                hold_off = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= !idle_on || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    task automatic send_word(input bit [7:0] b, input bit [15:0] plen, input bit f,
                             input bit l);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, b};
        s_tuser  <= f;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    task automatic sender_stop();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input bit [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.copy_limit = 32'(v);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void push32(input int unsigned v);
        pkt.push_back(v[7:0]);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[23:16]);
        pkt.push_back(v[31:24]);
    endfunction

    function automatic void push_value(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                pkt.push_back(8'h00);
            else if (r < 5)
                pkt.push_back(8'($urandom_range(1, 255)));
            else
                pkt.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    // a comment with a wanted key in mixed case, a short key, a near miss or junk
    function automatic void push_comment();
        int       sel;
        int       klen;
        int       vlen;
        int       i;
        int       bump;
        string    k;
        bit [7:0] c;
        sel  = $urandom_range(0, 9);
        k    = sb.tag_keys[$urandom_range(0, NUM_KEYS - 1)];
        vlen = $urandom_range(0, 10);
        klen = k.len();
        bump = -1;
        if (sel == 6) begin
            k    = "comment=";
            klen = k.len();
        end else if (sel == 7) begin
            klen = $urandom_range(0, k.len() - 1);
            vlen = 0;
        end else if (sel == 8) begin
            bump = $urandom_range(0, klen - 1);
        end
        push32(klen + vlen);
        for (i = 0; i < klen; i++) begin
            c = k[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - 8'd32;
            if (i == bump)
                c = c ^ 8'h01;
            pkt.push_back(c);
        end
        if (sel == 9 && vlen > 0) begin
            k = sb.tag_keys[$urandom_range(0, NUM_KEYS - 1)];
            for (i = 0; i < k.len(); i++)
                pkt.push_back(k[i]);
        end
        push_value(vlen);
        if (sel == 9 && vlen > 0) begin
            i = pkt.size() - 4 - klen - vlen - k.len();
            push_value(0);
            {pkt[i + 3], pkt[i + 2], pkt[i + 1], pkt[i]} = klen + vlen + k.len();
        end
    endfunction

    function automatic void build_tags(input int unsigned vlen, input int ncom);
        int i;
        pkt.delete();
        for (i = 0; i < MAGIC_LEN; i++)
            pkt.push_back(sb.magic_text[i]);
        vendor_len = vlen;
        push32(vlen);
        push_value(vlen);
        push32(ncom);
        repeat (ncom) push_comment();
    endfunction

    task automatic send_packet(input bit [15:0] declared, input int count, input bit close);
        int i;
        for (i = 0; i < count; i++)
            send_word(pkt[i], (i == 0) ? declared : 16'($urandom), i == 0,
                      close && i == count - 1);
    endtask

    task automatic random_packet();
        int choice;
        int n;
        int t;
        choice = $urandom_range(0, 99);
        build_tags($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12),
                   $urandom_range(0, 4));
        n = pkt.size();
        if (choice < 55) begin
            t = $urandom_range(0, 3);
            push_value(t);
            send_packet(16'($urandom_range(0, 1) ? n + t : n), pkt.size(), 1'b1);
        end else if (choice < 65) begin
            t = $urandom_range(0, n - 1);
            pkt[t] = pkt[t] ^ 8'($urandom_range(1, 255));
            send_packet(16'(n), n, 1'b1);
        end else if (choice < 72) begin
            send_packet(16'(n), $urandom_range(1, n - 1), 1'b1);
        end else if (choice < 78) begin
            send_packet(16'($urandom_range(0, n - 1)), n, 1'b1);
        end else if (choice < 84) begin
            if ($urandom_range(0, 1))
                pkt[11] = pkt[11] | 8'h80;
            else
                pkt[15 + vendor_len] = pkt[15 + vendor_len] | 8'h80;
            send_packet(16'(n), n, 1'b1);
        end else if (choice < 90) begin
            // dropped mid-packet by a new first byte
            send_packet(16'(n), $urandom_range(1, n - 1), 1'b0);
            build_tags($urandom_range(0, 8), $urandom_range(0, 3));
            send_packet(16'(pkt.size()), pkt.size(), 1'b1);
        end else if (choice < 95) begin
            repeat ($urandom_range(1, 6))
                send_word(8'($urandom), 16'($urandom), $urandom_range(0, 9) == 0,
                          $urandom_range(0, 3) == 0);
        end else begin
            send_word(8'($urandom), 16'($urandom), 1'b1, 1'b1);
        end
    endtask

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned phase_no;
        int unsigned target;
        bit [15:0]   limit;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte with no packet open, truncated huge packet, short packet, minimal packet
        send_word(8'h00, 16'h0000, 1'b0, 1'b1);
        send_word(8'hFF, 16'hFFFF, 1'b1, 1'b1);
        send_word(8'h4F, 16'd15, 1'b1, 1'b1);
        build_tags(0, 0);
        send_packet(16'd16, 16, 1'b1);
        sender_stop();
        wait_idle();

        for (phase_no = 0; phase_no < 6; phase_no++) begin
            case (phase_no)
                0:       limit = 16'd256;
                1:       limit = 16'd0;
                2:       limit = 16'hFFFF;
                3:       limit = 16'd3;
                4:       limit = 16'd1;
                default: limit = 16'($urandom_range(2, 20));
            endcase
            idle_on = (phase_no != 2);
            write_limit(limit);
            if (phase_no == 0) begin
                hold_off = 1'b1;
                build_tags(40, 1);
                send_packet(16'(pkt.size()), pkt.size(), 1'b1);
            end
            target = words_sent + 110;
            while (words_sent < target)
                random_packet();
            sender_stop();
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
